FILE: sv/mlr_pkg.sv
package mlr_pkg;
  localparam int unsigned WordBitsDef = 64;
endpackage

FILE: sv/mlr_if.sv
interface mlr_in_if #(parameter int unsigned WordBits = 64);
  logic                  valid;
  logic                  ready;
  logic [WordBits-1:0]   multiplier;
  logic [WordBits-2:0]   modulus;
  logic [WordBits-2:0]   count;
  modport source (output valid, multiplier, modulus, count, input ready);
  modport sink   (input valid, multiplier, modulus, count, output ready);
endinterface

interface mlr_out_if #(parameter int unsigned WordBits = 64);
  logic                  valid;
  logic                  ready;
  logic [WordBits-2:0]   low_index;
  logic [WordBits-2:0]   high_index;
  logic [WordBits-2:0]   low_residue;
  logic [WordBits-2:0]   high_residue;
  modport source (output valid, low_index, high_index, low_residue, high_residue,
                  input ready);
  modport sink   (input valid, low_index, high_index, low_residue, high_residue,
                  output ready);
endinterface

FILE: sv/mlr_div.sv
// Restoring divider, one quotient bit per cycle
module mlr_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [W:0]      trial;
  logic [W:0]      shifted;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, den_q};

  // Shift in one bit and subtract when it fits
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  // A finished division leaves no count behind
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> cnt_q == '0)
    else $error("divider done with count left");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (busy_q && !start_i) |=> (cnt_q < $past(cnt_q)))
    else $error("divider count stuck");
endmodule

FILE: sv/min_linear_residue_both_sides_top.sv
// Minimum linear residue on both sides of zero.
// Input channel in_i carries multiplier a (signed), modulus m and count n.
// Output channel out_o carries one result per request: least index and
// smallest residue of a*i mod m (low side) and of -a*i mod m (high side),
// over i in 1..n. A zero modulus or count is taken as one.
// One request at a time: in_i.ready is high only while the sequencer idles.
// Each request runs a reduction of a, then Euclid-like half rounds; every
// half round with a nonzero other residue uses the shared restoring
// divider twice, for the quotient and the index limit, then runs a
// shift-add multiply and an update step.
// The result is held in an output register until taken; a stalled receiver
// holds the next result back in the output state, nothing is lost.
// Reset clears the sequencer and the output valid; no request is in flight.
module min_linear_residue_both_sides_top #(
  parameter int unsigned WORD_BITS = mlr_pkg::WordBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mlr_in_if.sink    in_i,
  mlr_out_if.source out_o
);
  import mlr_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned HW = W - 1;
  localparam int unsigned MulCntW = $clog2(HW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_DK    = 4'd3;
  localparam logic [3:0] S_WK    = 4'd4;
  localparam logic [3:0] S_WL    = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]    st_q, st_d;
  logic          side_q, side_d;          // 0: update y,r ; 1: update x,l
  logic          neg_q, neg_d;
  logic [HW-1:0] m_q, m_d, n_q, n_d;
  logic [HW-1:0] x_q, x_d, y_q, y_d, l_q, l_d, r_q, r_d;
  logic [HW-1:0] k_q, k_d;
  logic [HW-1:0] pi_q, pi_d, pr_q, pr_d;
  logic [MulCntW-1:0] mcnt_q, mcnt_d;
  logic          clip_q, clip_d;
  logic          ovalid_q, ovalid_d;

  logic          dstart;
  logic [W-1:0]  dnum, dden, dquo, drem;
  logic          ddone;

  mlr_div #(.W(W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dstart),
    .num_i  (dnum),
    .den_i  (dden),
    .done_o (ddone),
    .quo_o  (dquo),
    .rem_o  (drem)
  );

  // Operands of the active side
  logic [HW-1:0] act_idx, oth_idx, act_res, oth_res;
  assign act_idx = side_q ? x_q : y_q;
  assign oth_idx = side_q ? y_q : x_q;
  assign act_res = side_q ? l_q : r_q;
  assign oth_res = side_q ? r_q : l_q;

  logic [HW-1:0] lim;
  assign lim = dquo[HW-1:0];

  logic [W-1:0] mag;
  assign mag = in_i.multiplier[W-1] ? (~in_i.multiplier + 1'b1) : in_i.multiplier;

  // Sequence the rounds
  always_comb begin
    st_d     = st_q;
    side_d   = side_q;
    neg_d    = neg_q;
    m_d = m_q; n_d = n_q;
    x_d = x_q; y_d = y_q; l_d = l_q; r_d = r_q;
    k_d = k_q; pi_d = pi_q; pr_d = pr_q; clip_d = clip_q;
    mcnt_d   = mcnt_q;
    ovalid_d = ovalid_q;
    dstart   = 1'b0;
    dnum     = '0;
    dden     = {1'b0, m_q};
    if (out_o.valid && out_o.ready) ovalid_d = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          m_d    = (in_i.modulus == '0) ? HW'(1) : in_i.modulus;
          n_d    = (in_i.count == '0) ? HW'(1) : in_i.count;
          neg_d  = in_i.multiplier[W-1];
          dstart = 1'b1;
          dnum   = mag;
          dden   = {1'b0, (in_i.modulus == '0) ? HW'(1) : in_i.modulus};
          st_d   = S_RED;
        end
      end
      S_RED: begin
        if (ddone) begin
          l_d  = (neg_q && drem != '0) ? (m_q - drem[HW-1:0]) : drem[HW-1:0];
          st_d = S_INIT;
        end
      end
      S_INIT: begin
        x_d = HW'(1); y_d = HW'(1); r_d = m_q - l_q; side_d = 1'b0;
        st_d = S_DK;
      end
      S_DK: begin
        // Divide the active residue by the other one
        if (oth_res == '0) begin
          if (side_q) begin x_d = y_q; l_d = '0; end
          else begin y_d = x_q; r_d = '0; end
          st_d = S_OUT;
        end else begin
          dstart = 1'b1;
          dnum   = {1'b0, act_res};
          dden   = {1'b0, oth_res};
          st_d   = S_WK;
        end
      end
      S_WK: begin
        if (ddone) begin
          k_d    = dquo[HW-1:0];
          dstart = 1'b1;
          dnum   = {1'b0, n_q - act_idx};
          dden   = {1'b0, oth_idx};
          st_d   = S_WL;
        end
      end
      S_WL: begin
        if (ddone) begin
          clip_d = lim < k_q;
          if (lim < k_q) k_d = lim;
          pi_d   = '0;
          pr_d   = '0;
          mcnt_d = MulCntW'(HW);
          st_d   = S_MUL;
        end
      end
      S_MUL: begin
        // Shift-add both products, quotient bits from the top
        pi_d   = {pi_q[HW-2:0], 1'b0} + (k_q[HW-1] ? oth_idx : '0);
        pr_d   = {pr_q[HW-2:0], 1'b0} + (k_q[HW-1] ? oth_res : '0);
        k_d    = {k_q[HW-2:0], 1'b0};
        mcnt_d = mcnt_q - 1'b1;
        if (mcnt_q == MulCntW'(1)) st_d = S_UPD;
      end
      S_UPD: begin
        if (side_q) begin x_d = x_q + pi_q; l_d = l_q - pr_q; end
        else begin y_d = y_q + pi_q; r_d = r_q - pr_q; end
        side_d = !side_q;
        st_d   = clip_q ? S_OUT : S_DK;
      end
      S_OUT: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          st_d     = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d; neg_q <= neg_d; m_q <= m_d; n_q <= n_d;
    x_q <= x_d; y_q <= y_d; l_q <= l_d; r_q <= r_d;
    k_q <= k_d; pi_q <= pi_d; pr_q <= pr_d; clip_q <= clip_d;
    mcnt_q <= mcnt_d;
  end

  // Hold the result until taken
  logic [HW-1:0] ox_q, oy_q, ol_q, or_q;
  always_ff @(posedge clk_i) begin
    if (st_q == S_OUT && !ovalid_q) begin
      ox_q <= x_q; oy_q <= y_q; ol_q <= l_q; or_q <= r_q;
    end
  end

  assign in_i.ready         = (st_q == S_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.low_index    = ox_q;
  assign out_o.high_index   = oy_q;
  assign out_o.low_residue  = ol_q;
  assign out_o.high_residue = or_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_i.valid && in_i.ready) |=> st_q == S_RED)
    else $error("request not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (st_q == S_OUT && !ovalid_q) |=> out_o.valid)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (st_q == S_UPD) |=> st_q == S_DK || st_q == S_OUT)
    else $error("bad round step");
endmodule
